// ----- sv/sdff_pkg.sv -----
package sdff_pkg;

  localparam int MaxFieldDef = 64;

  localparam int ValW     = 32;
  localparam int CharW    = 8;
  localparam int CfgW     = 7;
  localparam int CfgIdxW  = 3;
  localparam int LenW     = 8;
  localparam int DigN     = 10;
  localparam int DigIdxW  = 4;

  // register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIELD_WIDTH  = 3'd0,
    CFG_MIN_DIGITS   = 3'd1,
    CFG_LEFT_JUSTIFY = 3'd2,
    CFG_FORCE_PLUS   = 3'd3,
    CFG_SPACE_SIGN   = 3'd4,
    CFG_ZERO_PAD     = 3'd5
  } cfg_idx_e;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;

  // divide by ten: q = (x * ceil(2^35 / 10)) >> 35, exact for 32-bit x
  localparam logic [63:0] Recip10 = 64'h0000_0000_CCCC_CCCD;
  localparam int          Recip10Shift = 35;

  typedef struct packed {
    logic load;   // take a new value
    logic conv;   // peel one decimal digit
    logic size;   // work out field layout
    logic emit;   // load next character into output register
  } sdff_cmd_t;

  typedef struct packed {
    logic conv_last;   // digit being peeled is the top one
    logic size_empty;  // field has no characters
    logic emit_last;   // character being emitted ends the field
  } sdff_sts_t;

endpackage

// ----- sv/sdff_if.sv -----
interface sdff_in_if
  import sdff_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdff_out_if
  import sdff_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- sv/sdff_ctrl.sv -----
module sdff_ctrl
  import sdff_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  sdff_sts_t sts_i,
  output sdff_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSize = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) state_d = StSize;
      end
      StSize: begin
        cmd_o.size = 1'b1;
        state_d    = sts_i.size_empty ? StIdle : StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/sdff_dp.sv -----
module sdff_dp
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MaxFieldDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic signed [ValW-1:0] value_i,
  input  sdff_cmd_t              cmd_i,
  output sdff_sts_t              sts_o,
  output logic [CharW-1:0]       out_char_o,
  output logic                   last_o
);

  localparam int KW = $clog2(MAX_FIELD);

  // configuration
  logic [CfgW-1:0] fw_q;
  logic [CfgW-1:0] md_q;
  logic            lj_q, fplus_q, sspace_q, zpad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= '0;
      md_q     <= '1;  // -1: no precision
      lj_q     <= 1'b0;
      fplus_q  <= 1'b0;
      sspace_q <= 1'b0;
      zpad_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIELD_WIDTH:  fw_q     <= cfg_data_i;
        CFG_MIN_DIGITS:   md_q     <= cfg_data_i;
        CFG_LEFT_JUSTIFY: lj_q     <= cfg_data_i[0];
        CFG_FORCE_PLUS:   fplus_q  <= cfg_data_i[0];
        CFG_SPACE_SIGN:   sspace_q <= cfg_data_i[0];
        CFG_ZERO_PAD:     zpad_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // digit extraction, one digit per cycle
  logic [ValW-1:0]    mag_q;
  logic               neg_q, raw_zero_q;
  logic [DigIdxW-1:0] cnt_q;
  logic [3:0]         digit_q [DigN];
  logic [63:0]        prod;
  logic [ValW-1:0]    quot, quot10;
  logic [3:0]         rem;

  assign prod   = {32'b0, mag_q} * Recip10;
  assign quot   = ValW'(prod >> Recip10Shift);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = 4'(mag_q - quot10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.conv) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q      <= value_i[ValW-1];
      raw_zero_q <= (value_i == '0);
      mag_q      <= value_i[ValW-1] ? (ValW'(0) - ValW'(value_i)) : ValW'(value_i);
    end else if (cmd_i.conv) begin
      mag_q          <= quot;
      digit_q[cnt_q] <= rem;
    end
  end

  assign sts_o.conv_last = (quot == '0) || (cnt_q == DigIdxW'(DigN - 1));

  // field layout
  logic            has_prec;
  logic [LenW-1:0] nd, sl, wid, prec, zeros, used, spaces, total, emit_n;
  logic [LenW-1:0] b1_q, b2_q, b3_q, b4_q, last_idx_q;
  logic [CharW-1:0] sign_q;

  assign has_prec = !md_q[CfgW-1];
  assign wid      = LenW'(fw_q);
  assign prec     = LenW'(md_q[CfgW-2:0]);
  assign nd       = (raw_zero_q && has_prec && (prec == '0)) ? '0 : LenW'(cnt_q);
  assign sl       = LenW'(neg_q || fplus_q || sspace_q);

  always_comb begin
    zeros = '0;
    if (has_prec) begin
      if (prec > nd) zeros = prec - nd;
    end else if (zpad_q && !lj_q && (wid > nd + sl)) begin
      zeros = wid - nd - sl;
    end
    used   = nd + zeros + sl;
    spaces = (wid > used) ? wid - used : '0;
    total  = used + spaces;
    emit_n = (total > LenW'(MAX_FIELD)) ? LenW'(MAX_FIELD) : total;
  end

  assign sts_o.size_empty = (total == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.size) begin
      b1_q       <= lj_q ? '0 : spaces;
      b2_q       <= (lj_q ? '0 : spaces) + sl;
      b3_q       <= (lj_q ? '0 : spaces) + sl + zeros;
      b4_q       <= (lj_q ? '0 : spaces) + used;
      last_idx_q <= emit_n - 1'b1;
      sign_q     <= neg_q ? ChMinus : (fplus_q ? ChPlus : ChSpace);
    end
  end

  // character emission
  logic [KW-1:0]      k_q;
  logic [LenW-1:0]    k8, didx8;
  logic [DigIdxW-1:0] didx;
  logic [CharW-1:0]   ch;

  assign k8    = LenW'(k_q);
  assign didx8 = b4_q - 1'b1 - k8;
  assign didx  = didx8[DigIdxW-1:0];

  always_comb begin
    if (k8 < b1_q)      ch = ChSpace;
    else if (k8 < b2_q) ch = sign_q;
    else if (k8 < b3_q) ch = ChZero;
    else if (k8 < b4_q) ch = ChZero + CharW'(digit_q[didx]);
    else                ch = ChSpace;
  end

  assign sts_o.emit_last = (k8 == last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.size) begin
      k_q <= '0;
    end else if (cmd_i.emit) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_o <= ch;
      last_o     <= sts_o.emit_last;
    end
  end

endmodule

// ----- sv/signed_decimal_field_formatter_top.sv -----
// Formats one signed 32-bit value per input beat as printf "%d" text and
// sends it out one ASCII character per output beat, last set on the final
// character. Field width, precision (negative = none) and the left-justify,
// plus, space and zero-pad flags come from the write-only register port
// (index 0..5, in that order); write them only while the block is idle.
// Each value goes through these steps: take the beat, peel its decimal
// digits (1 to 10) through a shared divide-by-ten unit, lay out the
// field, then emit one character per cycle while the output takes beats.
// The emit loop is the limit for wide fields. Fields are clipped to
// MAX_FIELD characters; an empty field produces no output beat. The next
// value is accepted once the previous field has been handed to the output
// register, so its conversion overlaps the wait on the last character.
module signed_decimal_field_formatter_top
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MaxFieldDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  sdff_in_if.sink            in_if,
  sdff_out_if.source         out_if
);

  sdff_cmd_t cmd;
  sdff_sts_t sts;

  // sequencer: idle / digit peel / layout / emit
  sdff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // config regs, digit store, layout boundaries, output character register
  sdff_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .value_i    (in_if.value),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_char_o (out_if.out_char),
    .last_o     (out_if.last)
  );

  // an accepted beat always goes through conversion before the next is taken
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted back to back");

  // sequencer issues at most one command per cycle
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.conv, cmd.size, cmd.emit}))
    else $error("overlapping datapath commands");

  // never overwrite a character the sink has not taken
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_if.valid || out_if.ready))
    else $error("output register overwritten");

endmodule
